### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the RTL. They drop out in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every edge outside reset
`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Condition must never be seen outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  `ASSERT_CLK(name, clk, rst_n, !(cond))
`else
`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

### sv/ppe_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppe_pkg
// Shared types and constants of the postfix expression evaluator.
// ---------------------------------------------------------------------------
package ppe_pkg;

  // Characters the front end recognizes
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_CARET = 8'h5E;  // '^'

  // Result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_BADOP = 3'd3;
  localparam logic [2:0] ST_DIVZ  = 3'd4;

  // Command queue between front and back end
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  // Decoded operation of one character
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_DIGIT = 3'd1,
    OP_ADD   = 3'd2,
    OP_SUB   = 3'd3,
    OP_MUL   = 3'd4,
    OP_DIV   = 3'd5,
    OP_POW   = 3'd6
  } op_e;

  // One classified command
  typedef struct packed {
    op_e        op;
    logic [3:0] digit;
    logic       last;
  } item_t;

endpackage

### sv/ppe_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppe_front
// Accepts input beats and classifies each character into a stack command.
// ---------------------------------------------------------------------------
module ppe_front (
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    char_code_i,
  input  logic          end_of_expr_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output ppe_pkg::item_t q_item_o
);
  import ppe_pkg::*;

  logic is_digit;
  logic [7:0] digit_off;

  // Stall while the queue has no room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Decode the character
  assign is_digit  = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
  assign digit_off = char_code_i - CH_ZERO;

  always_comb begin
    q_item_o.last  = end_of_expr_i;
    q_item_o.digit = digit_off[3:0];
    if (is_digit) begin
      q_item_o.op = OP_DIGIT;
    end else begin
      unique case (char_code_i)
        CH_PLUS:  q_item_o.op = OP_ADD;
        CH_MINUS: q_item_o.op = OP_SUB;
        CH_STAR:  q_item_o.op = OP_MUL;
        CH_SLASH: q_item_o.op = OP_DIV;
        CH_CARET: q_item_o.op = OP_POW;
        default:  q_item_o.op = OP_NONE;
      endcase
    end
  end

endmodule

### sv/ppe_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppe_fifo
// Short command queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module ppe_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ppe_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ppe_pkg::item_t item_o
);
  import ppe_pkg::*;

  item_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wptr_q, wptr_d;
  logic [FIFO_AW-1:0]     rptr_q, rptr_d;
  logic [FIFO_AW:0]       cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and fill count
  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  `ASSERT_NEVER(a_fifo_cnt_range, clk_i, rst_ni, cnt_q > (FIFO_AW+1)'(FIFO_DEPTH))

endmodule

### sv/ppe_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppe_div
// Signed 32-bit divider, truncating toward zero, one quotient bit a cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module ppe_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quot_o
);
  logic        busy_q;
  logic [5:0]  cnt_q;
  logic        done_q;
  logic        neg_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] den_q;
  logic [31:0] res_q;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic [31:0] num_abs;
  logic [31:0] den_abs;

  assign num_abs = num_i[31] ? 32'd0 - num_i : num_i;
  assign den_abs = den_i[31] ? 32'd0 - den_i : den_i;
  assign shifted = {rem_q, quo_q[31]};
  assign diff    = shifted - {1'b0, den_q};
  assign done_o  = done_q;
  assign quot_o  = res_q;

  // Control: count 32 steps, then fix the sign
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == 6'd32) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // Datapath: restoring shift-subtract
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      quo_q <= num_abs;
      den_q <= den_abs;
      neg_q <= num_i[31] ^ den_i[31];
    end else if (busy_q) begin
      if (cnt_q == 6'd32) begin
        res_q <= neg_q ? 32'd0 - quo_q : quo_q;
      end else if (!diff[32]) begin
        rem_q <= diff[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= shifted[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  `ASSERT_CLK(a_div_done_idle, clk_i, rst_ni, done_q |-> !busy_q)

endmodule

### sv/ppe_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppe_back
// Executes stack commands: value stack, arithmetic, error tracking and the
// registered result beat.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module ppe_back #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  ppe_pkg::item_t     q_item_i,
  output logic               q_pop_o,
  output logic               div_start_o,
  output logic [31:0]        div_num_o,
  output logic [31:0]        div_den_o,
  input  logic               div_done_i,
  input  logic [31:0]        div_quot_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic [2:0]         status_o
);
  import ppe_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // Entries below the top of stack; the top lives in tos_q
  logic [31:0]   stack_mem [DEPTH];
  logic [31:0]   rd_q;
  logic [31:0]   tos_q, tos_d;
  logic [CW-1:0] count_q, count_d;
  logic [2:0]    err_q, err_d;
  logic [1:0]    state_q, state_d;
  op_e           op_q, op_d;
  logic          last_q, last_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   value_q, value_d;
  logic [2:0]    status_q, status_d;
  logic          we;
  logic [CW-1:0] wa_full;
  logic [CW-1:0] ra_full;
  logic [31:0]   prod;
  logic          out_free;

  assign wa_full     = count_q - CW'(1);
  assign ra_full     = count_q - CW'(2);
  assign prod        = rd_q * tos_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign div_num_o   = rd_q;
  assign div_den_o   = tos_q;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

  // Sequence one command at a time
  always_comb begin
    state_d     = state_q;
    tos_d       = tos_q;
    count_d     = count_q;
    err_d       = err_q;
    op_d        = op_q;
    last_d      = last_q;
    we          = 1'b0;
    div_start_o = 1'b0;
    out_valid_d = (out_valid_q && !out_stall_i) ? 1'b0 : out_valid_q;
    value_d     = value_q;
    status_d    = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          op_d    = q_item_i.op;
          last_d  = q_item_i.last;
          state_d = q_item_i.last ? S_FIN : S_IDLE;
          if (err_q == ST_OK) begin
            case (q_item_i.op) inside
              OP_DIGIT: begin
                if (count_q == CW'(DEPTH)) begin
                  err_d = ST_OVER;
                end else begin
                  we      = (count_q != '0);
                  tos_d   = {28'd0, q_item_i.digit};
                  count_d = count_q + CW'(1);
                end
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW: begin
                if (count_q < CW'(2)) begin
                  err_d = ST_UNDER;
                end else begin
                  state_d = S_READ;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_READ: begin
        // rd_q holds the first operand, tos_q the second
        state_d = last_q ? S_FIN : S_IDLE;
        case (op_q)
          OP_ADD: begin
            tos_d   = rd_q + tos_q;
            count_d = count_q - CW'(1);
          end
          OP_SUB: begin
            tos_d   = rd_q - tos_q;
            count_d = count_q - CW'(1);
          end
          OP_MUL: begin
            tos_d   = prod;
            count_d = count_q - CW'(1);
          end
          OP_DIV: begin
            if (tos_q == '0) begin
              err_d   = ST_DIVZ;
              count_d = count_q - CW'(2);
            end else begin
              div_start_o = 1'b1;
              state_d     = S_DIV;
            end
          end
          default: begin
            err_d   = ST_BADOP;
            count_d = count_q - CW'(2);
          end
        endcase
      end
      S_DIV: begin
        if (div_done_i) begin
          tos_d   = div_quot_i;
          count_d = count_q - CW'(1);
          state_d = last_q ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        // Report, then clear the stack and the error
        if (out_free) begin
          out_valid_d = 1'b1;
          if (err_q != ST_OK) begin
            status_d = err_q;
            value_d  = '0;
          end else if (count_q == '0) begin
            status_d = ST_UNDER;
            value_d  = '0;
          end else begin
            status_d = ST_OK;
            value_d  = tos_q;
          end
          count_d = '0;
          err_d   = ST_OK;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tos_q    <= tos_d;
    op_q     <= op_d;
    last_q   <= last_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  // Stack memory: spill the old top on push, read the first operand
  always_ff @(posedge clk_i) begin
    if (we) begin
      stack_mem[wa_full[AW-1:0]] <= tos_q;
    end
    rd_q <= stack_mem[ra_full[AW-1:0]];
  end

  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CW'(DEPTH))
  `ASSERT_CLK(a_div_clean, clk_i, rst_ni, (state_q == S_DIV) |-> (err_q == ST_OK))
  `ASSERT_CLK(a_fin_clears, clk_i, rst_ni,
    (state_q == S_FIN && out_free) |=> (count_q == '0 && err_q == ST_OK && out_valid_q))

endmodule

### sv/postfix_expression_evaluator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates a postfix expression given one character per beat.
// ---------------------------------------------------------------------------
// Send one ASCII character per input beat and mark the last one with
// end_of_expr_i; after it, one result beat carries the top of the stack and
// a status (ok, underflow, overflow, invalid operator, divide by zero, the
// first error wins, value reads 0 on error). The stack then empties for the
// next expression. A front end classifies characters into a four-entry
// command queue, so input keeps flowing while the back end works until the
// queue fills. The back end takes one command per cycle for digits and
// ignored characters; + - * and ^ also pass a read state that fetches the
// first operand from the stack memory, and / then waits on the bit-serial
// divider. The last character passes a final state that issues the result
// beat. The stack memory needs no clearing after reset.
module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  input  logic               end_of_expr_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic [2:0]         status_o
);
  import ppe_pkg::*;

  item_t       push_item;
  item_t       pop_item;
  logic        q_push;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic        div_start;
  logic [31:0] div_num;
  logic [31:0] div_den;
  logic        div_done;
  logic [31:0] div_quot;

  ppe_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .end_of_expr_i (end_of_expr_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (push_item)
  );

  ppe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  ppe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  ppe_back #(
    .DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (pop_item),
    .q_pop_o     (q_pop),
    .div_start_o (div_start),
    .div_num_o   (div_num),
    .div_den_o   (div_den),
    .div_done_i  (div_done),
    .div_quot_i  (div_quot),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

endmodule

### tb/sv/tb_postfix_expression_evaluator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_postfix_expression_evaluator
// Self-checking testbench of the postfix expression evaluator.
// ---------------------------------------------------------------------------
// Feeds postfix expressions one character per input beat. A behavioral
// stack machine in the bench predicts the value and status of each
// expression when its last character is accepted. Result beats are compared
// in order against those predictions. Directed expressions cover the
// operators, the error codes, a full stack and wraparound. Random
// expressions follow, mostly well formed, with random idle gaps on the input
// side and random stalls on the output side.
// ---------------------------------------------------------------------------
module tb_postfix_expression_evaluator;
  import ppe_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int          HALF_PERIOD = 5;
  localparam int          CYCLE_LIMIT = 2000000;
  localparam int          TAIL_CYCLES = 200;
  localparam int          HOLD_CYCLES = 300;

  typedef struct {
    logic [31:0] value;
    logic [2:0]  status;
  } expr_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [7:0]         char_code_i   = 8'h00;
  logic               end_of_expr_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic signed [31:0] value_o;
  logic [2:0]         status_o;

  // Predicted machine state
  logic [31:0]  calc_stack [DEPTH];
  int unsigned  calc_depth = 0;
  logic [2:0]   calc_error = ST_OK;
  expr_result_t pending_results [$];

  int  error_count   = 0;
  int  cycle_count   = 0;
  int  chars_sent    = 0;
  bit  tx_idle_en    = 1'b1;
  bit  rx_idle_en    = 1'b1;
  int  rx_hold_req   = 0;
  int  rx_hold_left  = 0;
  int  rx_burst_left = 0;

  postfix_expression_evaluator #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_code_i  (char_code_i),
    .end_of_expr_i(end_of_expr_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_o      (value_o),
    .status_o     (status_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached", $time);
      $display("tb_postfix_expression_evaluator: errors");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------
  function automatic op_e classify_char(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return OP_DIGIT;
    case (c)
      CH_PLUS:  return OP_ADD;
      CH_MINUS: return OP_SUB;
      CH_STAR:  return OP_MUL;
      CH_SLASH: return OP_DIV;
      CH_CARET: return OP_POW;
      default:  return OP_NONE;
    endcase
  endfunction

  function automatic logic [31:0] quotient_toward_zero(logic [31:0] num, logic [31:0] den);
    logic [31:0] num_mag;
    logic [31:0] den_mag;
    logic [31:0] quo;
    num_mag = num[31] ? 32'd0 - num : num;
    den_mag = den[31] ? 32'd0 - den : den;
    quo     = num_mag / den_mag;
    return (num[31] != den[31]) ? 32'd0 - quo : quo;
  endfunction

  // Push onto the predicted stack, flag overflow when full
  function automatic void push_value(logic [31:0] v);
    if (calc_depth >= DEPTH) begin
      calc_error = ST_OVER;
    end else begin
      calc_stack[calc_depth] = v;
      calc_depth++;
    end
  endfunction

  // Apply one accepted character; queue the result on the last one
  function automatic void evaluate_char(logic [7:0] c, bit last);
    op_e          op;
    logic [31:0]  lhs;
    logic [31:0]  rhs;
    expr_result_t res;
    op = classify_char(c);
    if (calc_error == ST_OK && op != OP_NONE) begin
      if (op == OP_DIGIT) begin
        push_value(32'(c) - 32'(CH_ZERO));
      end else if (calc_depth < 2) begin
        calc_error = ST_UNDER;
      end else begin
        rhs = calc_stack[calc_depth - 1];
        lhs = calc_stack[calc_depth - 2];
        calc_depth -= 2;
        case (op)
          OP_ADD: push_value(lhs + rhs);
          OP_SUB: push_value(lhs - rhs);
          OP_MUL: push_value(lhs * rhs);
          OP_DIV: begin
            if (rhs == 32'd0) calc_error = ST_DIVZ;
            else push_value(quotient_toward_zero(lhs, rhs));
          end
          default: calc_error = ST_BADOP;
        endcase
      end
    end
    if (last) begin
      res.value  = 32'd0;
      res.status = calc_error;
      if (calc_error == ST_OK) begin
        if (calc_depth == 0) res.status = ST_UNDER;
        else res.value = calc_stack[calc_depth - 1];
      end
      pending_results.push_back(res);
      calc_depth = 0;
      calc_error = ST_OK;
    end
  endfunction

  // ------------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    expr_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result beat: expected none, actual value %0d status %0d",
                 $time, value_o, status_o);
      end else begin
        want = pending_results.pop_front();
        if (value_o !== want.value) begin
          error_count++;
          $display("%0t: value mismatch: expected %0d, actual %0d",
                   $time, $signed(want.value), value_o);
        end
        if (status_o !== want.status) begin
          error_count++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, status_o);
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Output side: random stalls, plus a long hold-off on request
  // ------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_out_stall
    int r;
    if (rx_hold_left > 0) begin
      out_stall_i <= 1'b1;
      rx_hold_left--;
    end else if (rx_hold_req != 0) begin
      out_stall_i  <= 1'b1;
      rx_hold_left = rx_hold_req - 1;
      rx_hold_req  = 0;
    end else if (!rx_idle_en) begin
      out_stall_i <= 1'b0;
    end else if (rx_burst_left > 0) begin
      out_stall_i <= 1'b1;
      rx_burst_left--;
    end else begin
      out_stall_i <= 1'b0;
      r = $urandom_range(0, 99);
      if (r < 75)      rx_burst_left = 0;
      else if (r < 93) rx_burst_left = $urandom_range(1, 3);
      else if (r < 99) rx_burst_left = $urandom_range(4, 12);
      else             rx_burst_left = $urandom_range(30, 90);
    end
  end

  // ------------------------------------------------------------------------
  // Input side
  // ------------------------------------------------------------------------
  function automatic int pick_tx_gap();
    int r;
    if (!tx_idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Send one character beat; entered and left at a falling edge
  task automatic send_char(input logic [7:0] c, input bit last);
    int gap;
    gap = pick_tx_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    char_code_i   <= c;
    end_of_expr_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    evaluate_char(c, last);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Drop valid and wait until every predicted result has been seen
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_noise_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (classify_char(c) != OP_NONE) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] pick_operator();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return CH_PLUS;
    if (r < 60) return CH_MINUS;
    if (r < 85) return CH_STAR;
    if (r < 98) return CH_SLASH;
    return CH_CARET;
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Push 2 * 8^10, which wraps to the most negative value
  task automatic push_min_int();
    send_char(CH_ZERO + 8'd2, 1'b0);
    repeat (10) begin
      send_char(CH_ZERO + 8'd8, 1'b0);
      send_char(CH_STAR, 1'b0);
    end
  endtask

  // One random expression: mostly well formed, some tall, some broken
  task automatic send_random_expr();
    logic [7:0] chars [$];
    int depth;
    int pushes;
    int target;
    int push_pct;
    int shape;
    depth  = 0;
    pushes = 0;
    shape  = $urandom_range(0, 99);
    if (shape < 12) begin
      target = $urandom_range(1, 10);
      repeat (target) begin
        case ($urandom_range(0, 2))
          0:       chars.push_back(pick_digit());
          1:       chars.push_back(pick_operator());
          default: chars.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      push_pct = 55;
      target   = $urandom_range(1, 12);
      if (shape >= 97) begin
        target   = $urandom_range(60, 70);
        push_pct = 100;
      end else if (shape >= 85) begin
        target = $urandom_range(13, 40);
      end
      while (pushes < target) begin
        if ($urandom_range(0, 99) < 5) chars.push_back(pick_noise_char());
        if (depth < 2 || $urandom_range(0, 99) < push_pct) begin
          chars.push_back(pick_digit());
          depth++;
          pushes++;
        end else begin
          chars.push_back(pick_operator());
          depth--;
        end
      end
      while (depth > 1) begin
        chars.push_back(pick_operator());
        depth--;
      end
      if ($urandom_range(0, 3) == 0) chars.push_back(pick_noise_char());
    end
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_directed();
    send_string("5");
    send_string("27-");
    send_string("98*");
    send_string("29-4/");
    send_string("93^");
    send_string("70/");
    // underflow sticks through the rest of the expression
    send_string("+55+");
    // ignored character alone: empty stack at the end
    send_char(8'hFF, 1'b1);
    // extra values below the top, last beat on an ignored character
    send_char(CH_ZERO + 8'd1, 1'b0);
    send_char(CH_ZERO + 8'd2, 1'b0);
    send_char(8'h00, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_stack_limits();
    // exactly full stack
    repeat (DEPTH - 1) send_char(CH_NINE, 1'b0);
    send_char(CH_ZERO + 8'd7, 1'b1);
    // one push past full, then an operator that must be ignored
    repeat (DEPTH) send_char(CH_ZERO + 8'd3, 1'b0);
    send_char(CH_NINE, 1'b0);
    send_char(CH_PLUS, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_wrap_arith();
    // most negative value divided by minus one
    push_min_int();
    send_string("01-/");
    // most negative value minus one wraps to the most positive
    push_min_int();
    send_string("1-");
    // multiply overflow wraps to zero
    push_min_int();
    send_string("2*");
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b1;
    rx_hold_req = HOLD_CYCLES;
    repeat (40) send_string("34+");
    wait_results_drained();
    repeat (10) send_string("97/");
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int n_chars, input bit tx_idle, input bit rx_idle);
    int target;
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    target     = chars_sent + n_chars;
    while (chars_sent < target) send_random_expr();
    wait_results_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    test_directed();
    test_stack_limits();
    test_wrap_arith();
    test_backpressure();
    test_random_traffic(600, 1'b1, 1'b1);
    test_random_traffic(250, 1'b0, 1'b0);
    test_random_traffic(300, 1'b1, 1'b0);
    test_random_traffic(300, 1'b0, 1'b1);

    // Let any late beat show up
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      error_count += pending_results.size();
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end
    if (error_count == 0) begin
      $display("tb_postfix_expression_evaluator: clean");
    end else begin
      $display("tb_postfix_expression_evaluator: errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/ppe_pkg.sv
sv/ppe_front.sv
sv/ppe_fifo.sv
sv/ppe_div.sv
sv/ppe_back.sv
sv/postfix_expression_evaluator.sv
tb/sv/tb_postfix_expression_evaluator.sv
